@@ design/gaussian_component_merge_macros.svh @@
// assertion macros for the gaussian component merge checker
`ifndef GAUSSIAN_COMPONENT_MERGE_MACROS_SVH
`define GAUSSIAN_COMPONENT_MERGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define GCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// gcm_pkg
// request and result types of the gaussian component merge
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned VALUE_W = 2 * ROOT_W;

    typedef struct packed {
        logic [31:0]        weight_a;
        logic signed [31:0] location_a;
        logic [31:0]        bandwidth_a;
        logic [31:0]        weight_b;
        logic signed [31:0] location_b;
        logic [31:0]        bandwidth_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] merged_location;
        logic [31:0]        merged_bandwidth;
        logic               variance_clamped;
        logic               zero_weight_error;
    } t_res;

endpackage

@@ design/gcm_isqrt.sv @@
// ----------------------------------------------------------------------------
// gcm_isqrt
// pipelined integer square root, one root bit per stage, rounded down
// ----------------------------------------------------------------------------
module gcm_isqrt
    import gcm_pkg::*;
#(
    parameter int unsigned SIDE_W = 35
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int unsigned REM_W = ROOT_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [VALUE_W-1:0] val;
        logic [SIDE_W-1:0]  side;
    } t_sq;

    function automatic t_sq sq_step(t_sq p);
        t_sq              q;
        logic [REM_W+1:0] tmp;
        logic [REM_W+1:0] trial;
        q     = p;
        tmp   = {p.rem, p.val[VALUE_W-1 -: 2]};
        trial = {2'b00, p.root, 2'b01};
        q.val = {p.val[VALUE_W-3:0], 2'b00};
        if (tmp >= trial) begin
            q.rem  = REM_W'(tmp - trial);
            q.root = {p.root[ROOT_W-2:0], 1'b1};
        end else begin
            q.rem  = REM_W'(tmp);
            q.root = {p.root[ROOT_W-2:0], 1'b0};
        end
        return q;
    endfunction

    logic [ROOT_W-1:0] r_vld;
    t_sq               r_sq [ROOT_W];
    t_sq               n_sq [ROOT_W];
    t_sq               first;

    always_comb begin
        first.rem  = '0;
        first.root = '0;
        first.val  = i_value;
        first.side = i_side;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        if (k == 0) begin : g_head
            always_comb n_sq[k] = sq_step(first);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= i_valid;
                end
            end
        end else begin : g_body
            always_comb n_sq[k] = sq_step(r_sq[k-1]);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_sq[ROOT_W-1].root;
    assign o_side  = r_sq[ROOT_W-1].side;

endmodule

@@ design/gaussian_component_merge.sv @@
// ----------------------------------------------------------------------------
// gaussian_component_merge
// moment-matching merge of two weighted gaussian components, one dimension
// ----------------------------------------------------------------------------
// request channel: i_valid, o_stall, i_req; one request per dimension
// carrying both weights, locations and bandwidths
// result channel: o_valid, i_stall, o_res; exactly one result per request,
// in request order
// pipeline: 5 multiply and add stages, 65 long-division stages for the
// second moment with the mean division running alongside, 1 variance
// stage, 32 square-root stages
// throughput: one request per cycle while no result is held; the 65-step
// restoring divider and 32-step root are fully unrolled, one bit per stage
// reset clears every stage valid bit; no result is shown until new
// requests arrive
// a stalled result holds the whole pipeline: o_stall follows a held
// result, nothing is lost or repeated and bubbles keep their places
// zero total weight gives zero fields with zero_weight_error set
// ----------------------------------------------------------------------------
module gaussian_component_merge
    import gcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam int unsigned DIV_STEPS  = 65;
    localparam int unsigned MEAN_STEPS = 32;
    localparam int unsigned SIDE_W     = 35;

    typedef struct packed {
        logic [32:0] w;
        logic        zero;
        logic        mneg;
        logic [32:0] m_rem;
        logic [31:0] m_nq;
        logic [32:0] s_rem;
        logic [64:0] s_nq;
        logic [63:0] msq;
    } t_div;

    function automatic t_div div_step(t_div p, logic do_mean, logic do_sq);
        t_div        q;
        logic [33:0] t;
        logic [33:0] tm;
        q = p;
        t = {p.s_rem, p.s_nq[64]};
        if (t >= {1'b0, p.w}) begin
            q.s_rem = 33'(t - {1'b0, p.w});
            q.s_nq  = {p.s_nq[63:0], 1'b1};
        end else begin
            q.s_rem = 33'(t);
            q.s_nq  = {p.s_nq[63:0], 1'b0};
        end
        if (do_mean) begin
            tm = {p.m_rem, p.m_nq[31]};
            if (tm >= {1'b0, p.w}) begin
                q.m_rem = 33'(tm - {1'b0, p.w});
                q.m_nq  = {p.m_nq[30:0], 1'b1};
            end else begin
                q.m_rem = 33'(tm);
                q.m_nq  = {p.m_nq[30:0], 1'b0};
            end
        end
        if (do_sq) begin
            q.msq = p.m_nq * p.m_nq;
        end
        return q;
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // stage a: magnitudes and products
    logic        r_a_vld;
    logic [31:0] r_a_wa, r_a_wb;
    logic        r_a_na, r_a_nb;
    logic [63:0] r_a_pa, r_a_pb, r_a_ba2, r_a_bb2, r_a_ma2, r_a_mb2;
    logic        n_a_na, n_a_nb;
    logic [31:0] n_a_ma, n_a_mb;

    always_comb begin
        n_a_na = i_req.location_a[31];
        n_a_nb = i_req.location_b[31];
        n_a_ma = n_a_na ? 32'(-i_req.location_a) : 32'(i_req.location_a);
        n_a_mb = n_a_nb ? 32'(-i_req.location_b) : 32'(i_req.location_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_wa  <= i_req.weight_a;
            r_a_wb  <= i_req.weight_b;
            r_a_na  <= n_a_na;
            r_a_nb  <= n_a_nb;
            r_a_pa  <= i_req.weight_a * n_a_ma;
            r_a_pb  <= i_req.weight_b * n_a_mb;
            r_a_ba2 <= i_req.bandwidth_a * i_req.bandwidth_a;
            r_a_bb2 <= i_req.bandwidth_b * i_req.bandwidth_b;
            r_a_ma2 <= n_a_ma * n_a_ma;
            r_a_mb2 <= n_a_mb * n_a_mb;
        end
    end

    // stage b: signed numerator parts and moment sums
    logic        r_b_vld;
    logic [31:0] r_b_wa, r_b_wb;
    logic [63:0] r_b_pos, r_b_neg;
    logic [64:0] r_b_sa, r_b_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_wa  <= r_a_wa;
            r_b_wb  <= r_a_wb;
            r_b_pos <= (r_a_na ? 64'd0 : r_a_pa) + (r_a_nb ? 64'd0 : r_a_pb);
            r_b_neg <= (r_a_na ? r_a_pa : 64'd0) + (r_a_nb ? r_a_pb : 64'd0);
            r_b_sa  <= {1'b0, r_a_ba2} + {1'b0, r_a_ma2};
            r_b_sb  <= {1'b0, r_a_bb2} + {1'b0, r_a_mb2};
        end
    end

    // stage c: mean numerator and partial products of the moments
    logic        r_c_vld;
    logic [32:0] r_c_w;
    logic        r_c_mneg;
    logic [64:0] r_c_num;
    logic [63:0] r_c_pal, r_c_pbl;
    logic [64:0] r_c_pah, r_c_pbh;
    logic [32:0] n_c_w;

    assign n_c_w = {1'b0, r_b_wa} + {1'b0, r_b_wb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_w    <= n_c_w;
            r_c_mneg <= r_b_neg > r_b_pos;
            if (r_b_neg > r_b_pos) begin
                r_c_num <= {1'b0, r_b_neg - r_b_pos} + {32'd0, n_c_w} - 65'd1;
            end else begin
                r_c_num <= {1'b0, r_b_pos - r_b_neg};
            end
            r_c_pal <= r_b_sa[31:0] * r_b_wa;
            r_c_pbl <= r_b_sb[31:0] * r_b_wb;
            r_c_pah <= r_b_sa[64:32] * r_b_wa;
            r_c_pbh <= r_b_sb[64:32] * r_b_wb;
        end
    end

    // stage d: weighted moments
    logic        r_d_vld;
    logic [32:0] r_d_w;
    logic        r_d_mneg;
    logic [64:0] r_d_num;
    logic [96:0] r_d_ta, r_d_tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_w    <= r_c_w;
            r_d_mneg <= r_c_mneg;
            r_d_num  <= r_c_num;
            r_d_ta   <= {r_c_pah, 32'd0} + {33'd0, r_c_pal};
            r_d_tb   <= {r_c_pbh, 32'd0} + {33'd0, r_c_pbl};
        end
    end

    // stage e: total moment
    logic        r_e_vld;
    logic [32:0] r_e_w;
    logic        r_e_mneg;
    logic [64:0] r_e_num;
    logic [97:0] r_e_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_w    <= r_d_w;
            r_e_mneg <= r_d_mneg;
            r_e_num  <= r_d_num;
            r_e_s    <= {1'b0, r_d_ta} + {1'b0, r_d_tb};
        end
    end

    // division stages
    t_div                 div_init;
    t_div                 r_dv [DIV_STEPS];
    t_div                 n_dv [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dv_vld;

    always_comb begin
        div_init.w     = r_e_w;
        div_init.zero  = (r_e_w == 33'd0);
        div_init.mneg  = r_e_mneg;
        div_init.m_rem = r_e_num[64:32];
        div_init.m_nq  = r_e_num[31:0];
        div_init.s_rem = r_e_s[97:65];
        div_init.s_nq  = r_e_s[64:0];
        div_init.msq   = '0;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        if (j == 0) begin : g_head
            always_comb n_dv[j] = div_step(div_init, 1'b1, 1'b0);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[j] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[j] <= r_e_vld;
                end
            end
        end else begin : g_body
            always_comb begin
                n_dv[j] = div_step(r_dv[j-1], 1'(j < MEAN_STEPS), 1'(j == MEAN_STEPS));
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[j] <= 1'b0;
                end else if (en) begin
                    r_dv_vld[j] <= r_dv_vld[j-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j] <= n_dv[j];
            end
        end
    end

    // stage f: variance, clamp and saturation
    t_div              last;
    logic              r_f_vld;
    logic [63:0]       r_f_var;
    logic [SIDE_W-1:0] r_f_side;
    logic              n_f_clamp;
    logic [64:0]       n_f_v;
    logic [31:0]       n_f_mean;

    assign last      = r_dv[DIV_STEPS-1];
    assign n_f_clamp = last.s_nq < {1'b0, last.msq};
    assign n_f_v     = last.s_nq - {1'b0, last.msq};
    assign n_f_mean  = last.mneg ? 32'(-last.m_nq) : last.m_nq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_dv_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_var  <= n_f_clamp ? 64'd0 : n_f_v[63:0];
            r_f_side <= {last.zero, n_f_clamp, !n_f_clamp && n_f_v[64], n_f_mean};
        end
    end

    // square root
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    gcm_isqrt #(
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_value (r_f_var),
        .i_side  (r_f_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        o_valid = sq_vld;
        o_res.zero_weight_error = sq_side[34];
        if (sq_side[34]) begin
            o_res.merged_location  = '0;
            o_res.merged_bandwidth = '0;
            o_res.variance_clamped = 1'b0;
        end else begin
            o_res.merged_location  = sq_side[31:0];
            o_res.merged_bandwidth = sq_side[32] ? 32'hFFFF_FFFF : sq_root;
            o_res.variance_clamped = sq_side[33];
        end
    end

endmodule

@@ design/gcm_checker.sv @@
// ----------------------------------------------------------------------------
// gcm_checker
// port-level checks of the gaussian component merge
// ----------------------------------------------------------------------------
`include "gaussian_component_merge_macros.svh"

module gcm_checker
    import gcm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_res o_res
);

    logic res_zero;
    logic res_clamp;
    logic zero_clean;
    logic bw_zero;
    logic res_held;

    assign res_zero   = o_valid && o_res.zero_weight_error;
    assign res_clamp  = o_valid && o_res.variance_clamped;
    assign bw_zero    = o_res.merged_bandwidth == 32'd0;
    assign zero_clean = o_res.merged_location == 32'sd0 && bw_zero && !o_res.variance_clamped;
    assign res_held   = o_valid && i_stall;

    `GCM_ASSERT_NOW(a_zero_fields, res_zero, zero_clean, "zero weight result with nonzero fields")
    `GCM_ASSERT_NOW(a_clamp_bw, res_clamp, bw_zero, "clamped variance with nonzero bandwidth")
    `GCM_ASSERT_NOW(a_stall_src, o_stall, res_held, "request stall without a held result")
    `GCM_ASSERT_NEXT(a_hold, res_held, o_valid && $stable(o_res), "stalled result changed")

endmodule

bind gaussian_component_merge gcm_checker u_gcm_checker (.*);

@@ dv/tb_gaussian_component_merge.sv @@
// ----------------------------------------------------------------------------
// tb_gaussian_component_merge
// self-checking bench for the gaussian component merge: directed corner
// requests then random ones, random idling and stalls on both channels,
// every result compared field by field with an in-bench predictor
// ----------------------------------------------------------------------------
module tb_gaussian_component_merge;
    import gcm_pkg::*;

    class merge_scoreboard;
        t_res pending_q[$];
        int   fails;

        function new();
            fails = 0;
        endfunction

        static function logic [31:0] root_floor(logic [63:0] v);
            logic [31:0] r;
            logic [31:0] t;
            r = '0;
            for (int i = 31; i >= 0; i--) begin
                t = r | (32'd1 << i);
                if ({32'd0, t} * {32'd0, t} <= v) r = t;
            end
            return r;
        endfunction

        static function t_res merge(t_req q);
            t_res        r;
            logic [63:0] wa, wb, ma, mb, w, pos, neg, mmag, diff, msq;
            logic [31:0] la, lb;
            logic [127:0] mom, m2, var_w;
            logic        na, nb;
            r = '0;
            la = q.location_a;
            lb = q.location_b;
            na = la[31];
            nb = lb[31];
            wa = {32'd0, q.weight_a};
            wb = {32'd0, q.weight_b};
            ma = na ? (64'h1_0000_0000 - {32'd0, la}) : {32'd0, la};
            mb = nb ? (64'h1_0000_0000 - {32'd0, lb}) : {32'd0, lb};
            w = wa + wb;
            if (w == 0) begin
                r.zero_weight_error = 1'b1;
                return r;
            end
            pos = 0;
            neg = 0;
            if (na) neg += wa * ma; else pos += wa * ma;
            if (nb) neg += wb * mb; else pos += wb * mb;
            if (pos >= neg) begin
                mmag = (pos - neg) / w;
                r.merged_location = mmag[31:0];
            end else begin
                diff = neg - pos;
                mmag = diff / w + ((diff % w) != 0 ? 64'd1 : 64'd0);
                r.merged_location = 32'd0 - mmag[31:0];
            end
            msq = mmag * mmag;
            mom = 128'(wa) * (128'(q.bandwidth_a) * 128'(q.bandwidth_a) + 128'(ma) * 128'(ma))
                + 128'(wb) * (128'(q.bandwidth_b) * 128'(q.bandwidth_b)
                + 128'(mb) * 128'(mb));
            m2 = mom / 128'(w);
            if (m2 < 128'(msq)) begin
                r.variance_clamped = 1'b1;
            end else begin
                var_w = m2 - 128'(msq);
                r.merged_bandwidth = (var_w[127:64] != 0) ? 32'hFFFF_FFFF
                                                          : root_floor(var_w[63:0]);
            end
            return r;
        endfunction

        function void note_request(t_req q);
            pending_q = {pending_q, merge(q)};
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (pending_q.size() == 0) begin
                $display("%0t: result with none expected, got %h", $time, got);
                fails++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.merged_location !== exp.merged_location) begin
                $display("%0t: merged_location expected %h got %h", $time,
                         exp.merged_location, got.merged_location);
                fails++;
            end
            if (got.merged_bandwidth !== exp.merged_bandwidth) begin
                $display("%0t: merged_bandwidth expected %h got %h", $time,
                         exp.merged_bandwidth, got.merged_bandwidth);
                fails++;
            end
            if (got.variance_clamped !== exp.variance_clamped) begin
                $display("%0t: variance_clamped expected %b got %b", $time,
                         exp.variance_clamped, got.variance_clamped);
                fails++;
            end
            if (got.zero_weight_error !== exp.zero_weight_error) begin
                $display("%0t: zero_weight_error expected %b got %b", $time,
                         exp.zero_weight_error, got.zero_weight_error);
                fails++;
            end
        endfunction
    endclass

    localparam int RANDOM_REQS = 400;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    t_res o_res;

    merge_scoreboard sb = new();
    bit  tail_quiet = 1'b0;
    int  cycles = 0;
    t_req dir_q[$];

    gaussian_component_merge uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // request and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_request(i_req);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_res);
    end

    // result-side stall bursts
    initial begin
        @(posedge i_rst_n);
        while (!tail_quiet) begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    function automatic void add_directed(t_req q);
        dir_q = {dir_q, q};
    endfunction

    task automatic send_request(t_req q);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= q;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value(bit is_loc);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return is_loc ? 32'($signed($urandom_range(0, 512)) - 256) : 32'h0001_0000;
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            4: return is_loc ? {1'b1, 31'($urandom())} : 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return 32'($urandom_range(0, 32'h00FF_FFFF));
        endcase
    endfunction

    function automatic t_req random_request();
        t_req q;
        q.weight_a    = pick_value(1'b0);
        q.location_a  = pick_value(1'b1);
        q.bandwidth_a = pick_value(1'b0);
        q.weight_b    = pick_value(1'b0);
        q.location_b  = ($urandom_range(0, 4) == 0) ? q.location_a : pick_value(1'b1);
        q.bandwidth_b = pick_value(1'b0);
        case ($urandom_range(0, 9))
            0: q.weight_a = '0;
            1: q.weight_b = '0;
            2: begin q.weight_a = '0; q.weight_b = '0; end
            default: ;
        endcase
        return q;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero total weight, with and without other content
        add_directed('0);
        add_directed('{32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd5});
        // extremes of weights, locations and bandwidths
        add_directed('{32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
        add_directed('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
        add_directed('{32'hFFFF_FFFF, 32'h8000_0000, 32'd0,
                       32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0});
        add_directed('{32'd1, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0});
        add_directed('{32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 32'h7FFF_FFFF, 32'd0});
        // one weight zero
        add_directed('{32'd0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
                       32'h0003_0000});
        add_directed('{32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'd0, 32'h0001_0000,
                       32'h0003_0000});
        // negative mean rounded down, variance clamps to zero; the middle one has zero mean and variance
        add_directed('{32'd1, 32'd0, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0});
        add_directed('{32'd1, 32'd0, 32'd0, 32'd2, 32'd1, 32'd0});
        add_directed('{32'd3, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'hFFFF_FFFE, 32'd0});
        // identical components, tiny values and alternating bit patterns
        add_directed('{32'h0001_0000, 32'h0002_8000, 32'h0000_8000,
                       32'h0001_0000, 32'h0002_8000, 32'h0000_8000});
        add_directed('{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});
        add_directed('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
        foreach (dir_q[k]) send_request(dir_q[k]);
        idle_gap(1);

        // hold off until the pipeline has drained
        while (sb.pending_q.size() != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS - 60) tail_quiet = 1'b1;
            if (!tail_quiet && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 9));
            send_request(random_request());
        end
        idle_gap(1);
        tail_quiet = 1'b1;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
